// ----- design/pbq_pkg.sv -----
// Shared types, constants and register codes for the point box quantiser.
package pbq_pkg;

    // Fixed field widths.
    localparam int COORD_W            = 32;
    localparam int CODE_W             = 24;
    localparam int LEVEL_W            = 5;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 32;
    localparam int MAX_LEVEL_BITS_DEF = 24;
    localparam int AXES               = 3;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] BOX_MIN_RESET    = COORD_W'(0);
    localparam logic [COORD_W-1:0] BOX_MAX_RESET    = COORD_W'(65536);
    localparam logic [LEVEL_W-1:0] LEVEL_BITS_RESET = LEVEL_W'(16);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BOX_MIN_X  = 3'd0,
        REG_BOX_MIN_Y  = 3'd1,
        REG_BOX_MIN_Z  = 3'd2,
        REG_BOX_MAX_X  = 3'd3,
        REG_BOX_MAX_Y  = 3'd4,
        REG_BOX_MAX_Z  = 3'd5,
        REG_LEVEL_BITS = 3'd6
    } pbq_reg_t;

    // One input item: a point in signed Q16.16.
    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } pbq_in_t;

    // One result item: three grid codes.
    typedef struct packed {
        logic [CODE_W-1:0] code_x;
        logic [CODE_W-1:0] code_y;
        logic [CODE_W-1:0] code_z;
    } pbq_out_t;

    // Per-axis operands that travel unchanged down the divider chain.
    typedef struct packed {
        logic               zero;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] d;
    } pbq_axis_t;

endpackage

// ----- design/pbq_front.sv -----
// Entry stage: box offsets, range and the code-zero conditions per axis.
module pbq_front
    import pbq_pkg::*;
#(
    parameter int QW = MAX_LEVEL_BITS_DEF + 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          valid_in,
    input  pbq_in_t                       point,
    input  logic [AXES-1:0][COORD_W-1:0]  box_min,
    input  logic [AXES-1:0][COORD_W-1:0]  box_max,
    input  logic [LEVEL_W-1:0]            bits,
    output logic                          valid_out,
    output pbq_axis_t [AXES-1:0]          axis_out,
    output logic [AXES-1:0][COORD_W-1:0]  rem_out,
    output logic [AXES-1:0][QW-1:0]       q_out
);

    logic                         valid_reg;
    pbq_axis_t [AXES-1:0]         axis_reg;
    pbq_axis_t [AXES-1:0]         axis_next;
    logic [AXES-1:0][COORD_W-1:0] coord;

    assign coord[0] = point.coord_x;
    assign coord[1] = point.coord_y;
    assign coord[2] = point.coord_z;

    // Offset and range per axis; a positive difference always fits the coordinate width.
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            axis_next[k].zero = (bits == '0)
                             || ($signed(box_max[k]) <= $signed(box_min[k]))
                             || ($signed(coord[k]) <= $signed(box_min[k]));
            axis_next[k].r    = box_max[k] - box_min[k];
            axis_next[k].d    = coord[k] - box_min[k];
        end
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            axis_reg <= axis_next;
        end
    end

    // The division starts with the offset as its remainder and an empty quotient.
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            rem_out[k] = axis_reg[k].d;
            q_out[k]   = '0;
        end
    end

    assign valid_out = valid_reg;
    assign axis_out  = axis_reg;

endmodule

// ----- design/pbq_cell.sv -----
// One restoring division step for all three axes, registered.
module pbq_cell
    import pbq_pkg::*;
#(
    parameter int STEP = 0,
    parameter int QW   = MAX_LEVEL_BITS_DEF + 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [LEVEL_W-1:0]            bits,
    input  logic                          valid_in,
    input  pbq_axis_t [AXES-1:0]          axis_in,
    input  logic [AXES-1:0][COORD_W-1:0]  rem_in,
    input  logic [AXES-1:0][QW-1:0]       q_in,
    output logic                          valid_out,
    output pbq_axis_t [AXES-1:0]          axis_out,
    output logic [AXES-1:0][COORD_W-1:0]  rem_out,
    output logic [AXES-1:0][QW-1:0]       q_out
);

    logic                         valid_reg;
    pbq_axis_t [AXES-1:0]         axis_reg;
    logic [AXES-1:0][COORD_W-1:0] rem_reg;
    logic [AXES-1:0][COORD_W-1:0] rem_next;
    logic [AXES-1:0][QW-1:0]      q_reg;
    logic [AXES-1:0][QW-1:0]      q_next;
    logic [AXES-1:0][COORD_W:0]   rem_dbl;
    logic [AXES-1:0]              ge;
    logic                         active;

    // Steps beyond the configured bit count pass the item through unchanged.
    assign active = (bits >= LEVEL_W'(STEP));

    // Shift the remainder, try the subtraction and shift the quotient bit in.
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            rem_dbl[k] = {rem_in[k], 1'b0};
            ge[k]      = (rem_dbl[k] >= {1'b0, axis_in[k].r});
            if (active)
            begin
                rem_next[k] = ge[k] ? COORD_W'(rem_dbl[k] - {1'b0, axis_in[k].r})
                                    : COORD_W'(rem_dbl[k]);
                q_next[k]   = {q_in[k][QW-2:0], ge[k]};
            end
            else
            begin
                rem_next[k] = rem_in[k];
                q_next[k]   = q_in[k];
            end
        end
    end

    // Cell valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Cell payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            axis_reg <= axis_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
        end
    end

    assign valid_out = valid_reg;
    assign axis_out  = axis_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;

endmodule

// ----- design/pbq_back.sv -----
// Final stage: round half up, saturate and select the special-case codes.
module pbq_back
    import pbq_pkg::*;
#(
    parameter int QW = MAX_LEVEL_BITS_DEF + 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [LEVEL_W-1:0]            bits,
    input  logic                          valid_in,
    input  pbq_axis_t [AXES-1:0]          axis_in,
    input  logic [AXES-1:0][COORD_W-1:0]  rem_in,
    input  logic [AXES-1:0][QW-1:0]       q_in,
    output logic                          valid_out,
    output pbq_out_t                      result
);

    logic                         valid_reg;
    pbq_out_t                     result_reg;
    pbq_out_t                     result_next;
    logic [QW-1:0]                lv;
    logic [AXES-1:0][COORD_W:0]   a_sum;
    logic [AXES-1:0][COORD_W:0]   d_dbl;
    logic [AXES-1:0][COORD_W:0]   s_diff;
    logic [AXES-1:0]              dec;
    logic [AXES-1:0]              inc;
    logic [AXES-1:0]              full;
    logic [AXES-1:0][QW-1:0]      q_adj;
    logic [AXES-1:0][QW-1:0]      q_half;
    logic [AXES-1:0][QW-1:0]      q_sat;
    logic [AXES-1:0][CODE_W-1:0]  code;

    // Top code for the configured bit count.
    assign lv = (QW'(1) << bits) - QW'(1);

    // The doubled quotient is off by at most one; fix it from the remainder, then halve.
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            a_sum[k]  = {1'b0, rem_in[k]} + {1'b0, axis_in[k].r};
            d_dbl[k]  = {axis_in[k].d, 1'b0};
            s_diff[k] = a_sum[k] - d_dbl[k];
            dec[k]    = (a_sum[k] < d_dbl[k]);
            inc[k]    = !dec[k] && (s_diff[k] >= {1'b0, axis_in[k].r});
            full[k]   = (axis_in[k].d >= axis_in[k].r);
            if (dec[k])
            begin
                q_adj[k] = q_in[k] - QW'(1);
            end
            else if (inc[k])
            begin
                q_adj[k] = q_in[k] + QW'(1);
            end
            else
            begin
                q_adj[k] = q_in[k];
            end
            q_half[k] = q_adj[k] >> 1;
            q_sat[k]  = (q_half[k] > lv) ? lv : q_half[k];
            if (axis_in[k].zero)
            begin
                code[k] = '0;
            end
            else if (full[k])
            begin
                code[k] = CODE_W'(lv);
            end
            else
            begin
                code[k] = CODE_W'(q_sat[k]);
            end
        end
        result_next.code_x = code[0];
        result_next.code_y = code[1];
        result_next.code_z = code[2];
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign valid_out = valid_reg;
    assign result    = result_reg;

endmodule

// ----- design/point_box_quantiser.sv -----
// Point box quantiser top level: configuration, divider chain and output buffer.
// Pipeline: the entry stage that captures the item, MAX_LEVEL_BITS + 1 division cells,
// one rounding stage and the output register.
// Throughput: one item per cycle while the skid buffer is empty; a two-entry output
// buffer lets the chain keep moving after the output stalls until the skid buffer fills.
// Reset: asynchronous, active low; clears all valid bits and loads the register defaults.
module point_box_quantiser
    import pbq_pkg::*;
#(
    parameter int MAX_LEVEL_BITS = MAX_LEVEL_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pbq_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pbq_out_t               out_data
);

    localparam int QW    = MAX_LEVEL_BITS + 2;
    localparam int NCELL = MAX_LEVEL_BITS + 1;

    logic [AXES-1:0][COORD_W-1:0] box_min_reg;
    logic [AXES-1:0][COORD_W-1:0] box_max_reg;
    logic [LEVEL_W-1:0]           level_bits_reg;
    logic [LEVEL_W-1:0]           bits_eff;
    logic                         advance;

    logic                         valid_s [0:NCELL];
    pbq_axis_t [AXES-1:0]         axis_s  [0:NCELL];
    logic [AXES-1:0][COORD_W-1:0] rem_s   [0:NCELL];
    logic [AXES-1:0][QW-1:0]      q_s     [0:NCELL];

    logic                         tail_valid;
    pbq_out_t                     tail_data;
    logic                         out_valid_reg;
    pbq_out_t                     out_data_reg;
    logic                         skid_valid_reg;
    pbq_out_t                     skid_data_reg;
    logic                         take;
    logic                         pop;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                box_min_reg[k] <= BOX_MIN_RESET;
                box_max_reg[k] <= BOX_MAX_RESET;
            end
            level_bits_reg <= LEVEL_BITS_RESET;
        end
        else if (cfg_we)
        begin
            case (pbq_reg_t'(cfg_index))
                REG_BOX_MIN_X:  box_min_reg[0] <= cfg_data[COORD_W-1:0];
                REG_BOX_MIN_Y:  box_min_reg[1] <= cfg_data[COORD_W-1:0];
                REG_BOX_MIN_Z:  box_min_reg[2] <= cfg_data[COORD_W-1:0];
                REG_BOX_MAX_X:  box_max_reg[0] <= cfg_data[COORD_W-1:0];
                REG_BOX_MAX_Y:  box_max_reg[1] <= cfg_data[COORD_W-1:0];
                REG_BOX_MAX_Z:  box_max_reg[2] <= cfg_data[COORD_W-1:0];
                REG_LEVEL_BITS: level_bits_reg <= cfg_data[LEVEL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Bit counts above the supported maximum saturate.
    assign bits_eff = (level_bits_reg > LEVEL_W'(MAX_LEVEL_BITS))
                    ? LEVEL_W'(MAX_LEVEL_BITS) : level_bits_reg;

    // The whole chain moves together unless the output buffer is full.
    assign advance  = !skid_valid_reg;
    assign in_ready = advance;

    pbq_front #(
        .QW (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (in_valid),
        .point     (in_data),
        .box_min   (box_min_reg),
        .box_max   (box_max_reg),
        .bits      (bits_eff),
        .valid_out (valid_s[0]),
        .axis_out  (axis_s[0]),
        .rem_out   (rem_s[0]),
        .q_out     (q_s[0])
    );

    // Division chain, one quotient bit per cell.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        pbq_cell #(
            .STEP (i),
            .QW   (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .bits      (bits_eff),
            .valid_in  (valid_s[i]),
            .axis_in   (axis_s[i]),
            .rem_in    (rem_s[i]),
            .q_in      (q_s[i]),
            .valid_out (valid_s[i+1]),
            .axis_out  (axis_s[i+1]),
            .rem_out   (rem_s[i+1]),
            .q_out     (q_s[i+1])
        );
    end

    pbq_back #(
        .QW (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .bits      (bits_eff),
        .valid_in  (valid_s[NCELL]),
        .axis_in   (axis_s[NCELL]),
        .rem_in    (rem_s[NCELL]),
        .q_in      (q_s[NCELL]),
        .valid_out (tail_valid),
        .result    (tail_data)
    );

    // Output register with a one-item skid buffer behind it.
    assign take = tail_valid && advance;
    assign pop  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (take)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= tail_data;
            end
            else
            begin
                out_data_reg <= tail_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The skid buffer only holds an item while the output register holds one too.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds an item while the output register is empty");

    // The skid buffer fills only after a stalled output.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid buffer filled without an output stall");

    // An accepted item enters the entry stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_s[0])
        else $error("accepted item did not reach the entry stage");

endmodule
